/* sv/fbba_pkg.sv */
package fbba_pkg;

	localparam int MAX_BLOCKS = 1024;

	localparam int ADDR_W     = 32;
	localparam int BS_CFG_W   = 16;
	localparam int BS_W       = BS_CFG_W + 1;
	localparam int NB_W       = 11;
	localparam int CMD_W      = 2;
	localparam int STS_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'h0000_0003;

	localparam int WORD_W = (MAX_BLOCKS < 64) ? MAX_BLOCKS / 2 : 32;
	localparam int ROWS   = MAX_BLOCKS / WORD_W;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int ROW_AW = $clog2(ROWS);
	localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);

	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_RESET = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK           = 3'd0,
		STS_FULL         = 3'd1,
		STS_MISALIGNED   = 3'd2,
		STS_BELOW        = 3'd3,
		STS_BEYOND       = 3'd4,
		STS_ALREADY_FREE = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_BSIZE = 2'd1,
		CFG_NBLK  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC_RD,
		ST_ALLOC_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DIV,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [BS_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} free_pos_t;

	// lowest clear bit at or above the start position
	function automatic free_pos_t find_free(input logic [WORD_W-1:0] row,
		input logic [BIT_W-1:0] from);
		free_pos_t r;
		r.found = 1'b0;
		r.pos   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!row[i] && (BIT_W'(i) >= from)) begin
				r.found = 1'b1;
				r.pos   = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* sv/fbba_ram.sv */
module fbba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/fbba_div.sv */
module fbba_div
	import fbba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [ADDR_W-1:0]    dvd_q;
	logic [BS_W-1:0]      rem_q;
	logic [BS_W-1:0]      dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [BS_W:0]   rem_sh;
	logic            ge;
	logic [BS_W-1:0] rem_nx;

	// restoring division, one quotient bit a cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[ADDR_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? BS_W'(rem_sh - {1'b0, dsr_q}) : BS_W'(rem_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[ADDR_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

/* sv/fixed_block_bitmap_allocator_top.sv */
// Fixed-size block allocator over a used-bit map kept in a RAM of 32-bit rows. Raise start
// while busy is low to issue a command; exactly one result follows, shown for one cycle with
// done high, and it must be taken in that cycle since it cannot be held off. After reset the
// block is busy while it sweeps the map clear, one row a cycle; a reset-pool command runs the
// same sweep and then answers. An allocate runs a forward search for the next free block,
// reading further map rows as needed, before it answers. A free that passes the alignment and
// base checks runs a 32-step restoring divider, one quotient bit a cycle, and answers after it
// clears the block's bit in its map row, if set, or straight after the divide when the index
// lies beyond the pool; a rejected free, a full pool and the unused command answer without such
// work. Configuration writes are always ready and are to be made while the block is idle.
module fixed_block_bitmap_allocator_top
	import fbba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CMD_W-1:0]      command,
	input  logic [ADDR_W-1:0]     address,
	output logic                  done,
	output logic [ADDR_W-1:0]     block_address,
	output logic [STS_W-1:0]      status,
	output logic [NB_W-1:0]       free_blocks,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_nx;

	logic [ADDR_W-1:0]   base_q;
	logic [BS_CFG_W-1:0] bsize_q;
	logic [NB_W-1:0]     nblk_q;

	logic [IDX_W-1:0]  first_free_q;
	logic [IDX_W-1:0]  used_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] row_q;
	logic              chk_first_q;
	logic [ROW_AW-1:0] clr_row_q;
	logic              resp_q;
	logic [ADDR_W-1:0] prod_q;
	logic [ADDR_W-1:0] baddr_q;
	status_t           status_q;
	logic [NB_W-1:0]   fb_q;
	logic              done_q;

	logic [ADDR_W-1:0] base_eff;
	logic [BS_W-1:0]   bs_round;
	logic [BS_W-1:0]   bs_eff;
	logic [IDX_W-1:0]  nb_eff;
	logic [31:0]       nb_wide;

	logic              accept;
	logic              alloc_full;
	logic              free_mis;
	logic              free_below;
	logic              clr_last;

	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ROW_AW-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     div_beyond;

	logic [BIT_W-1:0]  ff_off;
	logic [BIT_W-1:0]  idx_off;
	logic [WORD_W-1:0] alloc_row;
	logic              alloc_bit;
	logic [WORD_W-1:0] free_row;
	logic              free_bit;
	logic [WORD_W-1:0] chk_row;
	free_pos_t         hit;
	logic [IDX_W-1:0]  cand;
	logic [IDX_W:0]    next_base;
	logic              next_end;
	logic [IDX_W-1:0]  fb_calc;

	// effective configuration
	always_comb begin
		base_eff = base_q & ~ALIGN_MASK;
		bs_round = ({1'b0, bsize_q} + BS_W'(3)) & ~BS_W'(3);
		bs_eff   = (bs_round < BS_W'(4)) ? BS_W'(4) : bs_round;
		nb_wide  = 32'(nblk_q);
		nb_eff   = (nb_wide > 32'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS) : IDX_W'(nb_wide);
	end

	assign accept     = start && (state_q == ST_IDLE);
	assign alloc_full = first_free_q >= nb_eff;
	assign free_mis   = (address & ALIGN_MASK) != '0;
	assign free_below = address < base_eff;
	assign clr_last   = clr_row_q == ROW_AW'(ROWS - 1);
	assign div_beyond = div_rsp.quotient >= 32'(nb_eff);

	always_comb begin
		ff_off    = first_free_q[BIT_W-1:0];
		idx_off   = idx_q[BIT_W-1:0];
		alloc_bit = ram_rdata[ff_off];
		alloc_row = ram_rdata | (WORD_W'(1) << ff_off);
		free_bit  = ram_rdata[idx_off];
		free_row  = ram_rdata & ~(WORD_W'(1) << idx_off);
		chk_row   = chk_first_q ? row_q : ram_rdata;
		hit       = find_free(chk_row, scan_idx_q[BIT_W-1:0]);
		cand      = {scan_idx_q[IDX_W-1:BIT_W], hit.pos};
		next_base = {1'b0, scan_idx_q[IDX_W-1:BIT_W], {BIT_W{1'b0}}} + (IDX_W+1)'(WORD_W);
		next_end  = next_base >= {1'b0, nb_eff};
		fb_calc   = (nb_eff > used_q) ? (nb_eff - used_q) : '0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_nx = resp_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(command))
						CMD_ALLOC: state_nx = alloc_full ? ST_FINISH : ST_ALLOC_RD;
						CMD_FREE:  state_nx = (free_mis || free_below) ? ST_FINISH : ST_DIV;
						CMD_RESET: state_nx = ST_CLEAR;
						default:   state_nx = ST_FINISH;
					endcase
				end
			end
			ST_ALLOC_RD: state_nx = ST_ALLOC_WR;
			ST_ALLOC_WR: state_nx = ST_SCAN_CHK;
			ST_SCAN_RD:  state_nx = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (hit.found || next_end) begin
					state_nx = ST_FINISH;
				end else begin
					state_nx = ST_SCAN_RD;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = div_beyond ? ST_FINISH : ST_FREE_RD;
				end
			end
			ST_FREE_RD: state_nx = ST_FREE_WR;
			ST_FREE_WR: state_nx = ST_FINISH;
			ST_FINISH:  state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		div_req.start    = 1'b0;
		div_req.dividend = address - base_eff;
		div_req.divisor  = bs_eff;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_row_q;
			end
			ST_IDLE: begin
				div_req.start = start && (cmd_t'(command) == CMD_FREE)
					&& !free_mis && !free_below;
			end
			ST_ALLOC_RD: ram_raddr = first_free_q[BIT_W+ROW_AW-1:BIT_W];
			ST_ALLOC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = first_free_q[BIT_W+ROW_AW-1:BIT_W];
				ram_wdata = alloc_row;
			end
			ST_SCAN_RD: ram_raddr = scan_idx_q[BIT_W+ROW_AW-1:BIT_W];
			ST_FREE_RD: ram_raddr = idx_q[BIT_W+ROW_AW-1:BIT_W];
			ST_FREE_WR: begin
				ram_we    = free_bit;
				ram_waddr = idx_q[BIT_W+ROW_AW-1:BIT_W];
				ram_wdata = free_row;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			base_q       <= '0;
			bsize_q      <= BS_CFG_W'(4);
			nblk_q       <= NB_W'(1024);
			first_free_q <= '0;
			used_q       <= '0;
			clr_row_q    <= '0;
			resp_q       <= 1'b0;
			chk_first_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BASE:  base_q  <= cfg_data;
					CFG_BSIZE: bsize_q <= cfg_data[BS_CFG_W-1:0];
					CFG_NBLK:  nblk_q  <= cfg_data[NB_W-1:0];
					default:   ;
				endcase
			end
			case (state_q)
				ST_CLEAR: clr_row_q <= clr_row_q + ROW_AW'(1);
				ST_IDLE: begin
					if (accept && (cmd_t'(command) == CMD_RESET)) begin
						first_free_q <= '0;
						used_q       <= '0;
						clr_row_q    <= '0;
						resp_q       <= 1'b1;
					end
				end
				ST_ALLOC_WR: begin
					if (!alloc_bit) begin
						used_q <= used_q + IDX_W'(1);
					end
					chk_first_q <= 1'b1;
				end
				ST_SCAN_CHK: begin
					chk_first_q <= 1'b0;
					if (hit.found) begin
						first_free_q <= (cand < nb_eff) ? cand : nb_eff;
					end else if (next_end) begin
						first_free_q <= nb_eff;
					end
				end
				ST_FREE_WR: begin
					if (free_bit) begin
						if (used_q != '0) begin
							used_q <= used_q - IDX_W'(1);
						end
						if (idx_q < first_free_q) begin
							first_free_q <= idx_q;
						end
					end
				end
				ST_FINISH: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result and working payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					baddr_q  <= '0;
					status_q <= STS_OK;
					prod_q   <= 32'(first_free_q) * 32'(bs_eff);
					case (cmd_t'(command))
						CMD_ALLOC: begin
							if (alloc_full) begin
								status_q <= STS_FULL;
							end
						end
						CMD_FREE: begin
							if (free_mis) begin
								status_q <= STS_MISALIGNED;
							end else if (free_below) begin
								status_q <= STS_BELOW;
							end
						end
						default: ;
					endcase
				end
			end
			ST_ALLOC_WR: begin
				baddr_q    <= base_eff + prod_q;
				row_q      <= alloc_row;
				scan_idx_q <= first_free_q;
			end
			ST_SCAN_CHK: begin
				if (!hit.found && !next_end) begin
					scan_idx_q <= next_base[IDX_W-1:0];
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					idx_q <= div_rsp.quotient[IDX_W-1:0];
					if (div_beyond) begin
						status_q <= STS_BEYOND;
					end
				end
			end
			ST_FREE_WR: begin
				if (!free_bit) begin
					status_q <= STS_ALREADY_FREE;
				end
			end
			ST_FINISH: fb_q <= NB_W'(fb_calc);
			default: ;
		endcase
	end

	fbba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fbba_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign busy          = state_q != ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign block_address = baddr_q;
	assign status        = status_q;
	assign free_blocks   = fb_q;

endmodule

/* sv/fbba_checker.sv */
module fbba_checker
	import fbba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [ADDR_W-1:0] block_address,
	input logic [STS_W-1:0]  status,
	input logic [NB_W-1:0]   free_blocks
);

	// a taken command makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("not busy after a command was taken");

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one beat");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STS_OK) |-> block_address == '0)
		else $error("address returned with a failing status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= STS_ALREADY_FREE) && (free_blocks <= NB_W'(MAX_BLOCKS)))
		else $error("status or free count out of range");

endmodule

bind fixed_block_bitmap_allocator_top fbba_checker u_fbba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.block_address(block_address),
	.status       (status),
	.free_blocks  (free_blocks)
);
